### sv/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_ORDER        = 10;
	localparam int DEF_STACK_DEPTH      = 1024;
	localparam int DEF_PAGE_NUMBER_BITS = 40;

	// Fixed field widths
	localparam int COUNT_W = 16;
	localparam int PAGE_W  = 40;
	localparam int FREE_W  = 22;
	localparam int ORD_W   = 5;   // order of a 16-bit page count: 0..16

	localparam logic [FREE_W-1:0] FREE_MAX = {FREE_W{1'b1}};

	// Operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NULL_FREE = 2'd3
	} status_t;

	// One finished result, handed from the controller to the output register
	typedef struct packed {
		status_t             status;
		logic [PAGE_W-1:0]   block_page;
		logic                pages_lost;
		logic [FREE_W-1:0]   free_pages_now;
	} result_t;

	// Smallest order whose block of 2^order pages covers the count (0 counts as 1)
	function automatic logic [ORD_W-1:0] count_to_order(input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] m;
		logic [ORD_W-1:0]   ord;
		m   = cnt - COUNT_W'(1);
		ord = '0;
		if (cnt > COUNT_W'(1)) begin
			for (int k = 0; k < COUNT_W; k++) begin
				if (m[k]) begin
					ord = ORD_W'(k + 1);
				end
			end
		end
		return ord;
	endfunction

endpackage
`default_nettype wire

### sv/bpa_stack_mem.sv
`default_nettype none
module bpa_stack_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 40
) (
	input  wire           clk,
	input  wire           we,
	input  wire  [AW-1:0] waddr,
	input  wire  [DW-1:0] wdata,
	input  wire           re,
	input  wire  [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl #(
	parameter int MAX_ORDER        = 10,
	parameter int STACK_DEPTH      = 1024,
	parameter int PAGE_NUMBER_BITS = 40
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire                             func,
	input  wire  [bpa_pkg::COUNT_W-1:0]     page_count,
	input  wire  [bpa_pkg::PAGE_W-1:0]      page_number,
	output logic                            res_valid,
	input  wire                             res_stall,
	output bpa_pkg::result_t                res
);
	import bpa_pkg::*;

	localparam int NUM = MAX_ORDER + 1;
	localparam int OW  = (NUM > 1) ? $clog2(NUM) : 1;
	localparam int FW  = $clog2(STACK_DEPTH + 1);
	localparam int PW  = PAGE_NUMBER_BITS;
	localparam int MD  = NUM * STACK_DEPTH;
	localparam int AW  = $clog2(MD);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EVAL  = 5'b00010,
		S_POP   = 5'b00100,
		S_SPLIT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic                func_q;
	logic [ORD_W-1:0]    ord_q;
	logic [PW-1:0]       page_q;
	logic [OW-1:0]       i_q;
	logic [PW-1:0]       block_q;
	status_t             status_q;
	logic                lost_q;
	logic [FW-1:0]       fill_q [NUM];
	logic [FREE_W-1:0]   free_q;

	logic [PW+PAGE_W-1:0] page_ext;
	logic [PW+PAGE_W-1:0] block_ext;
	logic [PW-1:0]        page_in;
	logic                 too_large;
	logic                 found;
	logic [OW-1:0]        sel;
	logic [OW-1:0]        ord_idx;
	logic [OW-1:0]        i_dn;
	logic                 split_more;
	logic [OW-1:0]        fidx;
	logic [FW-1:0]        fill_sel;
	logic                 fill_full;
	logic [PW-1:0]        buddy;
	logic [FREE_W:0]      add_sum;
	logic [FREE_W-1:0]    add_res;
	logic [FREE_W-1:0]    sub_ord;
	logic [FREE_W-1:0]    sub_split;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [PW-1:0]        mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [PW-1:0]        mem_rdata;

	// Mask the incoming page number to the stored width
	assign page_ext = {{PW{1'b0}}, page_number};
	assign page_in  = page_ext[PW-1:0];

	assign too_large  = ord_q > ORD_W'(MAX_ORDER);
	assign ord_idx    = ord_q[OW-1:0];
	assign i_dn       = i_q - OW'(1);
	assign split_more = ORD_W'(i_q) > ord_q;

	// Find the lowest nonempty stack at or above the wanted order
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int k = NUM - 1; k >= 0; k--) begin
			if ((fill_q[k] != '0) && (ORD_W'(k) >= ord_q)) begin
				found = 1'b1;
				sel   = OW'(k);
			end
		end
	end

	// Select the one fill level this cycle works on
	always_comb begin
		if (state_q == S_SPLIT) begin
			fidx = i_dn;
		end else if (func_q == FUNC_FREE) begin
			fidx = ord_idx;
		end else begin
			fidx = sel;
		end
	end
	assign fill_sel  = fill_q[fidx];
	assign fill_full = fill_sel == FW'(STACK_DEPTH);

	assign buddy = block_q + (PW'(1) << i_dn);

	// Free page counter arithmetic: saturate up, stop at zero down
	assign add_sum   = {1'b0, free_q} + ((FREE_W + 1)'(1) << ord_q);
	assign add_res   = add_sum[FREE_W] ? FREE_MAX : add_sum[FREE_W-1:0];
	assign sub_ord   = (FREE_W'(1) << ord_q) >= free_q ? '0 : free_q - (FREE_W'(1) << ord_q);
	assign sub_split = (FREE_W'(1) << i_dn) >= free_q ? '0 : free_q - (FREE_W'(1) << i_dn);

	// Memory port drive
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = page_q;
		mem_re    = 1'b0;
		mem_waddr = AW'(fidx) * AW'(STACK_DEPTH) + AW'(fill_sel);
		mem_raddr = AW'(fidx) * AW'(STACK_DEPTH) + AW'(fill_sel - FW'(1));
		if (state_q == S_EVAL) begin
			if (func_q == FUNC_FREE) begin
				mem_we = (page_q != '0) && !too_large && !fill_full;
			end else begin
				mem_re = !too_large && found;
			end
		end else if (state_q == S_SPLIT) begin
			mem_we    = split_more && !fill_full;
			mem_wdata = buddy;
		end
	end

	bpa_stack_mem #(
		.DEPTH(MD),
		.AW   (AW),
		.DW   (PW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Control: state, fill levels and free page count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= '0;
			for (int k = 0; k < NUM; k++) begin
				fill_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (func_q == FUNC_FREE) begin
						state_q <= S_DONE;
						if ((page_q != '0) && !too_large && !fill_full) begin
							fill_q[fidx] <= fill_sel + FW'(1);
							free_q       <= add_res;
						end
					end else if (too_large || !found) begin
						state_q <= S_DONE;
					end else begin
						fill_q[fidx] <= fill_sel - FW'(1);
						state_q      <= S_POP;
					end
				end
				S_POP: begin
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (split_more) begin
						if (fill_full) begin
							free_q <= sub_split;
						end else begin
							fill_q[fidx] <= fill_sel + FW'(1);
						end
					end else begin
						free_q  <= sub_ord;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				ord_q  <= count_to_order(page_count);
				page_q <= page_in;
			end
			S_EVAL: begin
				block_q  <= '0;
				lost_q   <= 1'b0;
				status_q <= ST_OK;
				i_q      <= sel;
				if (func_q == FUNC_FREE) begin
					if (page_q == '0) begin
						status_q <= ST_NULL_FREE;
					end else if (too_large) begin
						status_q <= ST_TOO_LARGE;
					end else if (fill_full) begin
						lost_q <= 1'b1;
					end
				end else if (too_large) begin
					status_q <= ST_TOO_LARGE;
				end else if (!found) begin
					status_q <= ST_OOM;
				end
			end
			S_POP: begin
				block_q <= mem_rdata;
			end
			S_SPLIT: begin
				if (split_more) begin
					i_q <= i_dn;
					if (fill_full) begin
						lost_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;

	assign block_ext          = {{PAGE_W{1'b0}}, block_q};
	assign res.status         = status_q;
	assign res.block_page     = block_ext[PAGE_W-1:0];
	assign res.pages_lost     = lost_q;
	assign res.free_pages_now = free_q;

endmodule
`default_nettype wire

### sv/buddy_page_allocator.sv
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   func, page_count, page_number
// out      output     out_valid/out_stall status, block_page, pages_lost, free_pages_now
//
// One item is in work at a time: a free or a rejected item goes from S_EVAL
// through S_DONE into the output register; an allocation goes through S_EVAL,
// S_POP, S_SPLIT and S_DONE, with L split levels, L at most MAX_ORDER, made by
// the split loop that writes one buddy per cycle into the single stack memory.
// Reset clears all stack fill levels and the free page count; the stack
// memory needs no clearing. A stalled result sits in the output register
// while the next item is accepted and worked on.
module buddy_page_allocator #(
	parameter int MAX_ORDER        = bpa_pkg::DEF_MAX_ORDER,
	parameter int STACK_DEPTH      = bpa_pkg::DEF_STACK_DEPTH,
	parameter int PAGE_NUMBER_BITS = bpa_pkg::DEF_PAGE_NUMBER_BITS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          func,
	input  wire  [bpa_pkg::COUNT_W-1:0]  page_count,
	input  wire  [bpa_pkg::PAGE_W-1:0]   page_number,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   status,
	output logic [bpa_pkg::PAGE_W-1:0]   block_page,
	output logic                         pages_lost,
	output logic [bpa_pkg::FREE_W-1:0]   free_pages_now
);
	import bpa_pkg::*;

	logic    res_valid;
	logic    res_stall;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	bpa_ctrl #(
		.MAX_ORDER       (MAX_ORDER),
		.STACK_DEPTH     (STACK_DEPTH),
		.PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.page_count (page_count),
		.page_number(page_number),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	// Hold the result until the output transaction completes
	assign res_stall = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!res_stall) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign block_page     = out_q.block_page;
	assign pages_lost     = out_q.pages_lost;
	assign free_pages_now = out_q.free_pages_now;

endmodule
`default_nettype wire

### tb/buddy_page_allocator_tb.sv
module buddy_page_allocator_tb;
	import bpa_pkg::*;

	localparam int PERIOD        = 12;
	localparam int MAX_ORD       = DEF_MAX_ORDER;
	localparam int DEPTH         = DEF_STACK_DEPTH;
	localparam int PAGE_BITS     = DEF_PAGE_NUMBER_BITS;
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;
	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_ITEMS  = 130;
	localparam int FLOOD_ITEMS   = 300;
	localparam int HOLD_ITEMS    = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 20;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [COUNT_W-1:0]  page_count;
	logic [PAGE_W-1:0]   page_number;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          status;
	logic [PAGE_W-1:0]   block_page;
	logic                pages_lost;
	logic [FREE_W-1:0]   free_pages_now;

	buddy_page_allocator dut (.*);

	// Predicted allocator state
	logic [PAGE_W-1:0]   free_stacks [0:MAX_ORD][0:DEPTH-1];
	int unsigned         stack_level [0:MAX_ORD];
	logic [FREE_W-1:0]   pool_pages;

	result_t             awaited_results [$];
	int                  fail_count;
	int                  quiet_cycles;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	bit                  hold_req;

	typedef struct {
		logic               op;
		logic [COUNT_W-1:0] cnt;
		logic [PAGE_W-1:0]  page;
		bit                 typed;
		result_t            res;
	} stim_row_t;

	// Directed sequence: rejects, empty-pool cases and the first free carry their result inline
	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{FUNC_ALLOC, 16'd0,     40'd0,            1'b1, '{ST_OOM, 40'd0, 1'b0, 22'd0}},
		'{FUNC_ALLOC, 16'd1024,  40'hFF_FFFF_FFFF, 1'b1, '{ST_OOM, 40'd0, 1'b0, 22'd0}},
		'{FUNC_ALLOC, 16'd1025,  40'd0,            1'b1,
			'{ST_TOO_LARGE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_ALLOC, 16'd65535, 40'd7,            1'b1,
			'{ST_TOO_LARGE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_FREE,  16'd1,     40'd0,            1'b1,
			'{ST_NULL_FREE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_FREE,  16'd65535, 40'd0,            1'b1,
			'{ST_NULL_FREE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_FREE,  16'd65535, 40'd5,            1'b1,
			'{ST_TOO_LARGE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_FREE,  16'd1025,  40'hFF_FFFF_FFFF, 1'b1,
			'{ST_TOO_LARGE, 40'd0, 1'b0, 22'd0}},
		'{FUNC_FREE,  16'd1024,  40'hFF_FFFF_FFFF, 1'b1, '{ST_OK, 40'd0, 1'b0, 22'd1024}},
		'{FUNC_ALLOC, 16'd1,     40'd0,            1'b0, '0},
		'{FUNC_ALLOC, 16'd0,     40'd0,            1'b0, '0},
		'{FUNC_ALLOC, 16'd2,     40'd0,            1'b0, '0},
		'{FUNC_FREE,  16'd0,     40'd1,            1'b0, '0},
		'{FUNC_FREE,  16'd512,   40'h00_0000_0200, 1'b0, '0},
		'{FUNC_ALLOC, 16'd513,   40'd0,            1'b0, '0},
		'{FUNC_ALLOC, 16'd512,   40'd0,            1'b0, '0},
		'{FUNC_FREE,  16'd1024,  40'h80_0000_0000, 1'b0, '0},
		'{FUNC_ALLOC, 16'd3,     40'hFF_FFFF_FFFF, 1'b0, '0},
		'{FUNC_FREE,  16'd16,    40'h55_5555_5550, 1'b0, '0},
		'{FUNC_FREE,  16'd32768, 40'hAA_AAAA_AAAA, 1'b0, '0},
		'{FUNC_ALLOC, 16'd16,    40'd0,            1'b0, '0},
		'{FUNC_ALLOC, 16'd1024,  40'd0,            1'b0, '0}
	};

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// Push onto the stack of one order; report false when the stack is full
	function automatic bit push_free_block(input int unsigned ord, input logic [PAGE_W-1:0] pg);
		if (stack_level[ord] >= DEPTH)
			return 1'b0;
		free_stacks[ord][stack_level[ord]] = pg & PAGE_MASK[PAGE_W-1:0];
		stack_level[ord]++;
		return 1'b1;
	endfunction

	// Take pages off the free count, stopping at zero
	function automatic void shrink_free(input int unsigned n);
		pool_pages = (n >= pool_pages) ? '0 : pool_pages - FREE_W'(n);
	endfunction

	// Apply one transaction to the predicted state and return its result
	function automatic result_t apply_page_op(input logic op, input logic [COUNT_W-1:0] cnt,
			input logic [PAGE_W-1:0] pg);
		result_t           r;
		int unsigned       want_ord;
		int unsigned       ord;
		logic [16:0]       span;
		logic [PAGE_W-1:0] pnum;
		logic [PAGE_W-1:0] blk;
		int unsigned       sum;
		pnum = pg & PAGE_MASK[PAGE_W-1:0];
		want_ord = 0;
		span = 17'd1;
		while (span < {1'b0, cnt}) begin
			span = span << 1;
			want_ord++;
		end
		r.status = ST_OK;
		r.block_page = '0;
		r.pages_lost = 1'b0;
		if (op == FUNC_FREE) begin
			if (pnum == '0) begin
				r.status = ST_NULL_FREE;
			end else if (want_ord > MAX_ORD) begin
				r.status = ST_TOO_LARGE;
			end else if (push_free_block(want_ord, pnum)) begin
				sum = pool_pages + (32'd1 << want_ord);
				pool_pages = (sum > FREE_MAX) ? FREE_MAX : FREE_W'(sum);
			end else begin
				r.pages_lost = 1'b1;
			end
		end else if (want_ord > MAX_ORD) begin
			r.status = ST_TOO_LARGE;
		end else begin
			ord = want_ord;
			while (ord <= MAX_ORD && stack_level[ord] == 0)
				ord++;
			if (ord > MAX_ORD) begin
				r.status = ST_OOM;
			end else begin
				stack_level[ord]--;
				blk = free_stacks[ord][stack_level[ord]];
				// split down, handing each upper buddy back to its stack
				while (ord > want_ord) begin
					ord--;
					if (!push_free_block(ord, blk + (PAGE_W'(1) << ord))) begin
						r.pages_lost = 1'b1;
						shrink_free(32'd1 << ord);
					end
				end
				shrink_free(32'd1 << want_ord);
				r.block_page = blk;
			end
		end
		r.free_pages_now = pool_pages;
		return r;
	endfunction

	// Offer one transaction, with random idle cycles ahead of it
	task automatic offer_item(input logic op, input logic [COUNT_W-1:0] cnt,
			input logic [PAGE_W-1:0] pg, input bit typed, input result_t typed_res);
		result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= op;
		page_count  <= cnt;
		page_number <= pg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_page_op(op, cnt, pg);
		awaited_results.push_back(typed ? typed_res : predicted);
	endtask

	function automatic logic [PAGE_W-1:0] random_page();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		if (raw[PAGE_W-1:0] == '0)
			raw = 64'd1;
		return raw[PAGE_W-1:0];
	endfunction

	// Random transaction: mostly counts that land on a valid order
	task automatic offer_random_item(input int alloc_pct);
		logic               op;
		logic [COUNT_W-1:0] cnt;
		logic [PAGE_W-1:0]  pg;
		int                 ord;
		op = ($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
		ord = $urandom_range(0, MAX_ORD);
		if ($urandom_range(0, 99) < 6)
			cnt = COUNT_W'($urandom());
		else if (ord == 0)
			cnt = COUNT_W'($urandom_range(0, 1));
		else
			cnt = COUNT_W'($urandom_range((1 << (ord - 1)) + 1, 1 << ord));
		pg = ($urandom_range(0, 99) < 6) ? '0 : random_page();
		offer_item(op, cnt, pg, 1'b0, '0);
	endtask

	// Drop valid and hold the sender until every result is back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		func           = FUNC_ALLOC;
		page_count     = '0;
		page_number    = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		fail_count     = 0;
		pool_pages     = '0;
		for (n = 0; n <= MAX_ORD; n++)
			stack_level[n] = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed sequence, no idling
		for (n = 0; n < DIRECTED_ROWS; n++)
			offer_item(directed_rows[n].op, directed_rows[n].cnt, directed_rows[n].page,
				directed_rows[n].typed, directed_rows[n].res);
		drain_results();

		// random, no idling
		for (n = 0; n < RANDOM_ITEMS; n++)
			offer_random_item(50);
		drain_results();

		// random, sender mostly idle
		send_idle_pct = 84;
		for (n = 0; n < RANDOM_ITEMS; n++)
			offer_random_item(40);
		drain_results();

		// random, receiver mostly stalled, then a long hold-off to back up the input
		send_idle_pct  = 0;
		recv_stall_pct = 84;
		for (n = 0; n < RANDOM_ITEMS; n++)
			offer_random_item(50);
		hold_req = 1'b1;
		for (n = 0; n < HOLD_ITEMS; n++)
			offer_random_item(50);
		drain_results();

		// both sides idle; fill order zero with frees, then drain by allocation
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		for (n = 0; n < FLOOD_ITEMS; n++)
			offer_item(FUNC_FREE, COUNT_W'($urandom_range(0, 1)), random_page(), 1'b0, '0);
		for (n = 0; n < RANDOM_ITEMS; n++)
			offer_random_item(70);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stall, or a long hold-off when one is requested
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Compare each result transaction against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$error("result transaction with nothing pending");
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (block_page !== want.block_page) begin
					$error("block_page: expected %h, got %h", want.block_page, block_page);
					fail_count++;
				end
				if (pages_lost !== want.pages_lost) begin
					$error("pages_lost: expected %0d, got %0d", want.pages_lost, pages_lost);
					fail_count++;
				end
				if (free_pages_now !== want.free_pages_now) begin
					$error("free_pages_now: expected %0d, got %0d",
						want.free_pages_now, free_pages_now);
					fail_count++;
				end
			end
		end
	end

	// Count cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		quiet_cycles = 0;
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
